// ----- sv/phwp_pkg.sv -----
`default_nettype none
package phwp_pkg;

  localparam int MIN_WORDS = 4;

  localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;
  localparam logic [7:0] CHAR_LOWER_LO = 8'h61;
  localparam logic [7:0] CHAR_LOWER_HI = 8'h66;
  localparam logic [7:0] CHAR_UPPER_LO = 8'h41;
  localparam logic [7:0] CHAR_UPPER_HI = 8'h46;
  localparam logic [7:0] LETTER_BIAS   = 8'h0A;

  localparam logic [1:0] NIB_MSB = 2'd3;
  localparam logic [1:0] NIB_LSB = 2'd0;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FEW      = 2'd1,
    STATUS_FIRST_NZ = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [15:0] word_value;
    logic [7:0]  word_index;
    logic        is_summary;
    logic [8:0]  word_count;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] nibble;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t       h;
    logic [7:0] diff;
    h    = '0;
    diff = '0;
    if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) begin
      diff = c - CHAR_DIGIT_LO;
      h.hit = 1'b1;
    end else if (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) begin
      diff = c - CHAR_LOWER_LO + LETTER_BIAS;
      h.hit = 1'b1;
    end else if (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) begin
      diff = c - CHAR_UPPER_LO + LETTER_BIAS;
      h.hit = 1'b1;
    end
    h.nibble = diff[3:0];
    return h;
  endfunction

endpackage
`default_nettype wire

// ----- sv/pronto_hex_word_parser_top.sv -----
`default_nettype none
// channel  ports                                          direction
// in       in_valid in_ready in_char_code in_end_of_text  request in
// out      out_valid out_ready out_word_value out_word_index
//          out_is_summary out_word_count out_status       result out
//
// One request per cycle sustained while out_ready holds; a result is offered
// on out_valid once its request has passed the input and result registers.
// Reset is synchronous: both registers empty, parser at the first nibble.
// A stalled result holds the step stage only when the request in it would
// yield another result; characters that yield nothing keep flowing.
module pronto_hex_word_parser_top #(
  parameter int MAX_WORDS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_end_of_text,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_word_value,
  output logic [7:0]       out_word_index,
  output logic             out_is_summary,
  output logic [8:0]       out_word_count,
  output logic [1:0]       out_status
);
  import phwp_pkg::*;

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    take;
  logic    res_valid;
  result_t res;
  logic    slot_free;
  logic    load;
  result_t out_res;

  assign in_item.char_code   = in_char_code;
  assign in_item.end_of_text = in_end_of_text;

  // advance unless a result is due and the result register is blocked
  assign take = s1_valid && (!res_valid || slot_free);
  assign load = take && res_valid;

  phwp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  phwp_step #(
    .MAX_WORDS (MAX_WORDS)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  phwp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_word_value = out_res.word_value;
  assign out_word_index = out_res.word_index;
  assign out_is_summary = out_res.is_summary;
  assign out_word_count = out_res.word_count;
  assign out_status     = out_res.status;

endmodule
`default_nettype wire

// ----- sv/phwp_in_reg.sv -----
`default_nettype none
module phwp_in_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire phwp_pkg::item_t in_item,
  input  wire logic           take,
  output logic                s1_valid,
  output phwp_pkg::item_t     s1_item
);
  import phwp_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_ready = !valid_r || take;
  assign s1_valid = valid_r;
  assign s1_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  // a held request must not be lost or altered while the step stage stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !take |=> valid_r && $stable(item_r))
    else $error("input stage dropped or changed a stalled request");

endmodule
`default_nettype wire

// ----- sv/phwp_step.sv -----
`default_nettype none
module phwp_step #(
  parameter int MAX_WORDS = 256
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            s1_valid,
  input  wire phwp_pkg::item_t s1_item,
  input  wire logic            take,
  output logic                 res_valid,
  output phwp_pkg::result_t    res
);
  import phwp_pkg::*;

  localparam int CW = $clog2(MAX_WORDS + 1);

  logic [1:0]      pos_r,   pos_nxt;
  logic [15:0]     acc_r,   acc_nxt;
  logic [CW-1:0]   done_r,  done_nxt;
  logic            fnz_r,   fnz_nxt;

  hex_t            dec;
  logic [15:0]     merged;
  logic [15:0]     word;
  logic            at_limit;
  logic [CW+8:0]   done_ext;

  assign dec      = hex_decode(s1_item.char_code);
  assign at_limit = (done_r == CW'(MAX_WORDS));
  assign done_ext = {{9{1'b0}}, done_r};

  always_comb begin
    merged = acc_r;
    case (pos_r)
      2'd3:    merged[15:12] = dec.nibble;
      2'd2:    merged[11:8]  = dec.nibble;
      2'd1:    merged[7:4]   = dec.nibble;
      default: merged[3:0]   = dec.nibble;
    endcase
    word = merged;
    // zero words past the header read as one
    if (merged == 16'd0 && done_r > CW'(MIN_WORDS - 1)) begin
      word = 16'd1;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    done_nxt  = done_r;
    fnz_nxt   = fnz_r;
    res_valid = 1'b0;
    res       = '0;
    if (s1_valid) begin
      if (s1_item.end_of_text) begin
        res_valid      = 1'b1;
        res.is_summary = 1'b1;
        res.word_count = done_ext[8:0];
        if (done_r < CW'(MIN_WORDS)) begin
          res.status = STATUS_FEW;
        end else if (fnz_r) begin
          res.status = STATUS_FIRST_NZ;
        end else begin
          res.status = STATUS_OK;
        end
        pos_nxt  = NIB_MSB;
        acc_nxt  = '0;
        done_nxt = '0;
        fnz_nxt  = 1'b0;
      end else if (!at_limit && dec.hit) begin
        if (pos_r == NIB_LSB) begin
          res_valid      = 1'b1;
          res.word_value = word;
          res.word_index = done_ext[7:0];
          if (done_r == '0 && word != 16'd0) begin
            fnz_nxt = 1'b1;
          end
          done_nxt = done_r + 1'b1;
          acc_nxt  = '0;
          pos_nxt  = NIB_MSB;
        end else begin
          acc_nxt = merged;
          pos_nxt = pos_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= NIB_MSB;
      acc_r  <= '0;
      done_r <= '0;
      fnz_r  <= 1'b0;
    end else if (take) begin
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      done_r <= done_nxt;
      fnz_r  <= fnz_nxt;
    end
  end

  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    done_r <= CW'(MAX_WORDS))
    else $error("word counter ran past the limit");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    take && s1_item.end_of_text |=> pos_r == NIB_MSB && done_r == '0 && acc_r == '0)
    else $error("parser not cleared after end of text");

  a_noop: assert property (@(posedge clk) disable iff (!rst_n)
    take && !res_valid |=> $stable(done_r))
    else $error("word count moved without a result");

endmodule
`default_nettype wire

// ----- sv/phwp_out_reg.sv -----
`default_nettype none
module phwp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire phwp_pkg::result_t res,
  output logic                   slot_free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output phwp_pkg::result_t      out_res
);
  import phwp_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> slot_free)
    else $error("result register overwritten while occupied");

endmodule
`default_nettype wire
